// ===== sv/hap_pkg.sv =====
// ----------------------------------------------------------------------------
// Hot address profiler package
// Shared item types, register indexes and fixed constants.
// ----------------------------------------------------------------------------
package hap_pkg;

    localparam int ADDR_BITS  = 64;
    localparam int HIT_BITS   = 32;
    localparam int HASH_SHIFT = 2;
    localparam int TOP_BITS   = 7;

    localparam logic [TOP_BITS-1:0] TOP_RESET = 7'd25;
    localparam logic [TOP_BITS-1:0] MAX_TOP   = 7'd64;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_DUMP   = 1'b1;

    localparam logic REG_ENABLE    = 1'b0;
    localparam logic REG_TOP_COUNT = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [ADDR_BITS-1:0] address;
    } cmd_t;

    typedef struct packed {
        logic                 found;
        logic [ADDR_BITS-1:0] hot_address;
        logic [HIT_BITS-1:0]  hit_count;
        logic                 last;
    } res_t;

endpackage

// ===== sv/hap_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/hap_fifo.sv =====
// ----------------------------------------------------------------------------
// Small FIFO
// Register-based queue used for the command and the result sides.
// ----------------------------------------------------------------------------
module hap_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    cnt_reg;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = data_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/hap_engine.sv =====
// ----------------------------------------------------------------------------
// Hot address profiler engine
// Clears the table, probes slots for records and scans the table for dumps.
// ----------------------------------------------------------------------------
module hap_engine
    import hap_pkg::*;
#(
    parameter int SLOTS       = 4096,
    parameter int PROBE_DEPTH = 8,
    parameter int COUNT_BITS  = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TOP_BITS-1:0] top_count,
    input  logic                cmd_valid,
    input  cmd_t                cmd_item,
    output logic                cmd_pop,
    input  logic                res_full,
    output logic                res_push,
    output res_t                res_item,
    output logic                clearing
);

    localparam int IW = $clog2(SLOTS);
    localparam int KW = $clog2(PROBE_DEPTH + 1);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_PROBE    = 8'b0000_0100,
        S_SCAN     = 8'b0000_1000,
        S_SCAN_END = 8'b0001_0000,
        S_FETCH    = 8'b0010_0000,
        S_TAKE     = 8'b0100_0000,
        S_FLUSH    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [IW-1:0]         idx_reg, idx_next;
    logic [IW-1:0]         home_reg, home_next;
    logic [ADDR_BITS-1:0]  addr_reg, addr_next;
    logic [KW-1:0]         pk_reg, pk_next;
    logic                  rd_v_reg, rd_v_next;
    logic [KW-1:0]         rd_k_reg, rd_k_next;
    logic [IW-1:0]         rd_idx_reg, rd_idx_next;
    logic [COUNT_BITS-1:0] home_cnt_reg, home_cnt_next;
    logic [IW-1:0]         best_idx_reg, best_idx_next;
    logic [COUNT_BITS-1:0] best_cnt_reg, best_cnt_next;
    logic                  pend_v_reg, pend_v_next;
    logic [ADDR_BITS-1:0]  pend_addr_reg, pend_addr_next;
    logic [COUNT_BITS-1:0] pend_cnt_reg, pend_cnt_next;
    logic [TOP_BITS-1:0]   n_reg, n_next;
    logic [TOP_BITS-1:0]   limit_reg, limit_next;

    logic [IW-1:0]         raddr, waddr;
    logic                  cnt_we, adr_we;
    logic [COUNT_BITS-1:0] cnt_wdata, cnt_rd;
    logic [ADDR_BITS-1:0]  adr_rd;
    logic                  hit, best_upd;
    logic [COUNT_BITS-1:0] best_cnt_cmb;
    logic [IW-1:0]         best_idx_cmb;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    hap_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (waddr),
        .wdata (cnt_wdata),
        .raddr (raddr),
        .rdata (cnt_rd)
    );

    hap_ram #(.WIDTH(ADDR_BITS), .DEPTH(SLOTS)) u_adr_ram (
        .clk   (clk),
        .we    (adr_we),
        .waddr (waddr),
        .wdata (addr_reg),
        .raddr (raddr),
        .rdata (adr_rd)
    );

    assign clearing     = (state_reg == S_CLEAR);
    assign hit          = (cnt_rd == '0) || (adr_rd == addr_reg);
    assign best_upd     = rd_v_reg && (cnt_rd > best_cnt_reg);
    assign best_cnt_cmb = best_upd ? cnt_rd : best_cnt_reg;
    assign best_idx_cmb = best_upd ? rd_idx_reg : best_idx_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        home_next      = home_reg;
        addr_next      = addr_reg;
        pk_next        = pk_reg;
        home_cnt_next  = home_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_cnt_next  = best_cnt_reg;
        pend_v_next    = pend_v_reg;
        pend_addr_next = pend_addr_reg;
        pend_cnt_next  = pend_cnt_reg;
        n_next         = n_reg;
        limit_next     = limit_reg;
        raddr          = idx_reg;
        waddr          = rd_idx_reg;
        cnt_we         = 1'b0;
        adr_we         = 1'b0;
        cnt_wdata      = '0;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_item       = '0;
        rd_v_next      = 1'b0;
        rd_k_next      = pk_reg;

        case (state_reg)
            S_CLEAR:
            begin
                cnt_we   = 1'b1;
                waddr    = idx_reg;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_item.cmd == CMD_RECORD)
                    begin
                        addr_next  = cmd_item.address;
                        home_next  = cmd_item.address[HASH_SHIFT +: IW];
                        pk_next    = '0;
                        state_next = S_PROBE;
                    end
                    else
                    begin
                        n_next        = '0;
                        pend_v_next   = 1'b0;
                        idx_next      = '0;
                        best_cnt_next = '0;
                        if (top_count == '0)
                        begin
                            limit_next = TOP_BITS'(1);
                        end
                        else if (top_count > MAX_TOP)
                        begin
                            limit_next = MAX_TOP;
                        end
                        else
                        begin
                            limit_next = top_count;
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            S_PROBE:
            begin
                // Reads are issued one a cycle; each is checked in the cycle after it is issued.
                raddr = home_reg + IW'(pk_reg);
                if (pk_reg < KW'(PROBE_DEPTH))
                begin
                    rd_v_next = 1'b1;
                    pk_next   = pk_reg + 1'b1;
                end
                if (rd_v_reg)
                begin
                    if (rd_k_reg == '0)
                    begin
                        home_cnt_next = cnt_rd;
                    end
                    if (hit)
                    begin
                        cnt_we     = 1'b1;
                        adr_we     = 1'b1;
                        cnt_wdata  = sat_inc(cnt_rd);
                        state_next = S_IDLE;
                    end
                    else if (rd_k_reg == KW'(PROBE_DEPTH - 1))
                    begin
                        // No slot qualified: the home slot still counts.
                        cnt_we     = 1'b1;
                        waddr      = home_reg;
                        cnt_wdata  = sat_inc((rd_k_reg == '0) ? cnt_rd : home_cnt_reg);
                        state_next = S_IDLE;
                    end
                end
            end
            S_SCAN:
            begin
                raddr         = idx_reg;
                rd_v_next     = 1'b1;
                idx_next      = idx_reg + 1'b1;
                best_cnt_next = best_cnt_cmb;
                best_idx_next = best_idx_cmb;
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_SCAN_END;
                end
            end
            S_SCAN_END:
            begin
                best_cnt_next = best_cnt_cmb;
                best_idx_next = best_idx_cmb;
                state_next    = (best_cnt_cmb == '0) ? S_FLUSH : S_FETCH;
            end
            S_FETCH:
            begin
                raddr      = best_idx_reg;
                state_next = S_TAKE;
            end
            S_TAKE:
            begin
                raddr = best_idx_reg;
                // The previous entry is sent only once it is known not to be the last.
                if (!(pend_v_reg && res_full))
                begin
                    if (pend_v_reg)
                    begin
                        res_push             = 1'b1;
                        res_item.found       = 1'b1;
                        res_item.hot_address = pend_addr_reg;
                        res_item.hit_count   = HIT_BITS'(pend_cnt_reg);
                    end
                    pend_v_next    = 1'b1;
                    pend_addr_next = adr_rd;
                    pend_cnt_next  = best_cnt_reg;
                    cnt_we         = 1'b1;
                    waddr          = best_idx_reg;
                    n_next         = n_reg + 1'b1;
                    idx_next       = '0;
                    best_cnt_next  = '0;
                    state_next     = (n_reg + 1'b1 == limit_reg) ? S_FLUSH : S_SCAN;
                end
            end
            S_FLUSH:
            begin
                if (!res_full)
                begin
                    res_push             = 1'b1;
                    res_item.found       = pend_v_reg;
                    res_item.hot_address = pend_v_reg ? pend_addr_reg : '0;
                    res_item.hit_count   = pend_v_reg ? HIT_BITS'(pend_cnt_reg) : '0;
                    res_item.last        = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        rd_idx_next = raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            idx_reg    <= '0;
            pk_reg     <= '0;
            rd_v_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            n_reg      <= '0;
            limit_reg  <= TOP_BITS'(1);
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            pk_reg     <= pk_next;
            rd_v_reg   <= rd_v_next;
            pend_v_reg <= pend_v_next;
            n_reg      <= n_next;
            limit_reg  <= limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        home_reg      <= home_next;
        addr_reg      <= addr_next;
        rd_k_reg      <= rd_k_next;
        rd_idx_reg    <= rd_idx_next;
        home_cnt_reg  <= home_cnt_next;
        best_idx_reg  <= best_idx_next;
        best_cnt_reg  <= best_cnt_next;
        pend_addr_reg <= pend_addr_next;
        pend_cnt_reg  <= pend_cnt_next;
    end

endmodule

// ===== sv/hot_address_profiler_top.sv =====
// ----------------------------------------------------------------------------
// Hot address profiler
// Hashed histogram of instruction addresses with a top-entries dump.
// ----------------------------------------------------------------------------
// After reset the block sweeps the count table once, one slot a cycle, so full
// stays high for the whole sweep; configuration writes are taken throughout.
// Items pass a two-entry command queue into the engine, which runs one item at
// a time. A record probes one table read a cycle and checks each read in the
// cycle after it is issued. A dump makes one full table scan per entry, as the
// count memory has a single read port, and may wait for room in the result
// queue. Results wait in a two-entry result queue. SLOTS must be a power of
// two.
module hot_address_profiler_top
    import hap_pkg::*;
#(
    parameter int SLOTS       = 4096,
    parameter int PROBE_DEPTH = 8,
    parameter int COUNT_BITS  = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 cmd,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 empty,
    input  logic                 pop,
    output logic                 found,
    output logic [ADDR_BITS-1:0] hot_address,
    output logic [HIT_BITS-1:0]  hit_count,
    output logic                 last,
    input  logic                 cfg_we,
    input  logic                 cfg_addr,
    input  logic [TOP_BITS-1:0]  cfg_data
);

    logic                enable_reg;
    logic [TOP_BITS-1:0] top_count_reg;
    logic                q_full, q_empty, q_pop, clearing;
    logic                res_full, res_push;
    cmd_t                q_in, q_out;
    res_t                res_in, res_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            top_count_reg <= TOP_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == REG_ENABLE)
            begin
                enable_reg <= cfg_data[0];
            end
            else
            begin
                top_count_reg <= cfg_data;
            end
        end
    end

    // Items that arrive while disabled are transferred and dropped here.
    assign full       = q_full || clearing;
    assign q_in.cmd     = cmd;
    assign q_in.address = address;

    hap_fifo #(.WIDTH($bits(cmd_t)), .DEPTH(2)) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !full && enable_reg),
        .wdata (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_out),
        .empty (q_empty)
    );

    hap_engine #(
        .SLOTS       (SLOTS),
        .PROBE_DEPTH (PROBE_DEPTH),
        .COUNT_BITS  (COUNT_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .top_count (top_count_reg),
        .cmd_valid (!q_empty),
        .cmd_item  (q_out),
        .cmd_pop   (q_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_item  (res_in),
        .clearing  (clearing)
    );

    hap_fifo #(.WIDTH($bits(res_t)), .DEPTH(2)) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_out),
        .empty (empty)
    );

    assign found       = res_out.found;
    assign hot_address = res_out.hot_address;
    assign hit_count   = res_out.hit_count;
    assign last        = res_out.last;

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> full)
        else $error("item could be transferred during the clearing pass");

    a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !found) |-> (last && hit_count == '0))
        else $error("empty dump result is not a lone final result");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full result queue");

endmodule
